// ----- sv/chm_pkg.sv -----
package chm_pkg;

	localparam int MAX_BUCKETS  = 1024;
	localparam int POOL_ENTRIES = 4096;
	localparam int BKT_W        = $clog2(MAX_BUCKETS);
	localparam int SLOT_W       = $clog2(POOL_ENTRIES);
	localparam int LINK_W       = SLOT_W + 1;
	localparam int CFG_W        = 11;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 32;
	localparam int Q_DEPTH      = 2;
	localparam int MOD_STEPS    = 4;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);

	localparam logic [1:0] FUNC_FIND   = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic [BKT_W-1:0]        bucket;
	} chm_item_t;

endpackage

// ----- sv/chm_if.sv -----
interface chm_req_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               func;
	logic [chm_pkg::KEY_W-1:0]                key;
	logic signed [chm_pkg::VAL_W-1:0]         value;

	modport source (output valid, func, key, value, input ready);
	modport sink (input valid, func, key, value, output ready);
endinterface

interface chm_rsp_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               status;
	logic signed [chm_pkg::VAL_W-1:0]         found_value;
	logic [chm_pkg::SLOT_W-1:0]               entry_index;

	modport source (output valid, status, found_value, entry_index, input ready);
	modport sink (input valid, status, found_value, entry_index, output ready);
endinterface

// ----- sv/chm_front.sv -----
module chm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	chm_req_if.sink                     req,
	input  logic [chm_pkg::CFG_W-1:0]   bucket_count,
	output logic                        push,
	output chm_pkg::chm_item_t          push_item,
	input  logic                        q_full
);

	logic                        busy_q;
	logic                        done_q;
	logic [2:0]                  cnt_q;
	logic [chm_pkg::BKT_W-1:0]   rem_q;
	logic [chm_pkg::KEY_W-1:0]   sh_q;
	logic [1:0]                  func_q;
	logic [chm_pkg::KEY_W-1:0]   key_q;
	logic signed [chm_pkg::VAL_W-1:0] value_q;
	logic [chm_pkg::CFG_W-1:0]   divisor;
	logic [chm_pkg::BKT_W-1:0]   rem_next;

	// A zero count acts as one bucket, anything above the table size as the full table.
	always_comb begin
		if (bucket_count == '0)
			divisor = chm_pkg::CFG_W'(1);
		else if (bucket_count > chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS))
			divisor = chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS);
		else
			divisor = bucket_count;
	end

	// Restoring remainder, several key bits per cycle, most significant first.
	always_comb begin
		logic [chm_pkg::CFG_W-1:0] t;
		t = chm_pkg::CFG_W'(rem_q);
		for (int i = 0; i < chm_pkg::MOD_STEPS; i++) begin
			t = {t[chm_pkg::CFG_W-2:0], sh_q[chm_pkg::KEY_W-1-i]};
			if (t >= divisor)
				t = t - divisor;
		end
		rem_next = t[chm_pkg::BKT_W-1:0];
	end

	assign req.ready = !busy_q;
	assign push      = busy_q && done_q && !q_full;

	always_comb begin
		push_item.func   = func_q;
		push_item.key    = key_q;
		push_item.value  = value_q;
		push_item.bucket = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q && !done_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'(chm_pkg::KEY_W / chm_pkg::MOD_STEPS - 1))
				done_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			key_q   <= req.key;
			value_q <= req.value;
			sh_q    <= req.key;
			rem_q   <= '0;
		end else if (busy_q && !done_q) begin
			sh_q  <= sh_q << chm_pkg::MOD_STEPS;
			rem_q <= rem_next;
		end
	end

endmodule

// ----- sv/chm_queue.sv -----
module chm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  chm_pkg::chm_item_t push_item,
	output logic               full,
	output logic               pop_valid,
	input  logic               pop,
	output chm_pkg::chm_item_t pop_item
);

	localparam int PW = (chm_pkg::Q_DEPTH > 1) ? $clog2(chm_pkg::Q_DEPTH) : 1;

	chm_pkg::chm_item_t                 slots_q [chm_pkg::Q_DEPTH];
	logic [PW-1:0]                      wr_q;
	logic [PW-1:0]                      rd_q;
	logic [$clog2(chm_pkg::Q_DEPTH+1)-1:0] cnt_q;

	assign full      = cnt_q == ($bits(cnt_q))'(chm_pkg::Q_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_item  = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(chm_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(chm_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + ($bits(cnt_q))'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - ($bits(cnt_q))'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_item;
	end

endmodule

// ----- sv/chm_back.sv -----
module chm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  chm_pkg::chm_item_t q_item,
	output logic               q_pop,
	chm_rsp_if.source          rsp
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DEL  = 3'd4;

	localparam int LW = chm_pkg::LINK_W;
	localparam int SW = chm_pkg::SLOT_W;
	localparam int BW = chm_pkg::BKT_W;

	logic [LW-1:0] heads_mem [chm_pkg::MAX_BUCKETS];
	logic [LW-1:0] links_mem [chm_pkg::POOL_ENTRIES];
	logic [chm_pkg::KEY_W-1:0] keys_mem [chm_pkg::POOL_ENTRIES];
	logic [chm_pkg::VAL_W-1:0] vals_mem [chm_pkg::POOL_ENTRIES];

	logic [2:0]                 state_q;
	chm_pkg::chm_item_t         item_q;
	logic [LW-1:0]              cur_q;
	logic [LW-1:0]              prev_q;
	logic [LW-1:0]              fh_q;
	logic [LW-1:0]              hw_q;
	logic [BW-1:0]              clr_q;
	logic                       clr_emit_q;
	logic                       out_valid_q;
	logic [1:0]                 out_status_q;
	logic signed [chm_pkg::VAL_W-1:0] out_value_q;
	logic [SW-1:0]              out_index_q;

	logic [LW-1:0]              head_rd;
	logic [LW-1:0]              link_rd;
	logic [chm_pkg::KEY_W-1:0]  key_rd;
	logic [chm_pkg::VAL_W-1:0]  val_rd;

	logic                       take;
	logic                       head_re;
	logic                       ent_re;
	logic [SW-1:0]              ent_ra;
	logic                       head_we;
	logic [BW-1:0]              head_wa;
	logic [LW-1:0]              head_wd;
	logic                       link_we;
	logic [SW-1:0]              link_wa;
	logic [LW-1:0]              link_wd;
	logic                       data_we;
	logic                       match;
	logic                       fresh;

	assign take  = state_q == S_IDLE && q_valid && (!out_valid_q || rsp.ready);
	assign q_pop = take;
	assign match = key_rd == item_q.key;
	// Slots at or above the high-water mark have never been allocated, so their links are not used.
	assign fresh = fh_q >= hw_q;

	assign head_re = take && q_item.func != chm_pkg::FUNC_CLEAR;

	always_comb begin
		ent_re  = 1'b0;
		ent_ra  = '0;
		head_we = 1'b0;
		head_wa = item_q.bucket;
		head_wd = '0;
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		data_we = 1'b0;
		unique case (state_q)
			S_CLR: begin
				head_we = 1'b1;
				head_wa = clr_q;
				head_wd = chm_pkg::NULL_LINK;
			end
			S_IDLE: begin
				ent_re = take && q_item.func == chm_pkg::FUNC_INSERT && !fh_q[SW];
				ent_ra = fh_q[SW-1:0];
			end
			S_HEAD: begin
				if (item_q.func == chm_pkg::FUNC_INSERT) begin
					if (!fh_q[SW]) begin
						data_we = 1'b1;
						head_we = 1'b1;
						head_wd = fh_q;
						link_we = 1'b1;
						link_wa = fh_q[SW-1:0];
						link_wd = head_rd;
					end
				end else begin
					ent_re = !head_rd[SW];
					ent_ra = head_rd[SW-1:0];
				end
			end
			S_CMP: begin
				if (match) begin
					if (item_q.func == chm_pkg::FUNC_DELETE) begin
						if (prev_q[SW]) begin
							head_we = 1'b1;
							head_wd = link_rd;
						end else begin
							link_we = 1'b1;
							link_wa = prev_q[SW-1:0];
							link_wd = link_rd;
						end
					end
				end else begin
					ent_re = !link_rd[SW];
					ent_ra = link_rd[SW-1:0];
				end
			end
			S_DEL: begin
				link_we = 1'b1;
				link_wa = cur_q[SW-1:0];
				link_wd = fh_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we)
			heads_mem[head_wa] <= head_wd;
		if (head_re)
			head_rd <= heads_mem[q_item.bucket];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			links_mem[link_wa] <= link_wd;
		if (data_we) begin
			keys_mem[fh_q[SW-1:0]] <= item_q.key;
			vals_mem[fh_q[SW-1:0]] <= item_q.value;
		end
		if (ent_re) begin
			link_rd <= links_mem[ent_ra];
			key_rd  <= keys_mem[ent_ra];
			val_rd  <= vals_mem[ent_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_emit_q  <= 1'b0;
			fh_q        <= '0;
			hw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(chm_pkg::MAX_BUCKETS - 1)) begin
						state_q <= S_IDLE;
						fh_q    <= '0;
						hw_q    <= '0;
						if (clr_emit_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= chm_pkg::ST_OK;
							out_value_q  <= '0;
							out_index_q  <= '0;
						end
					end
				end
				S_IDLE: begin
					if (take) begin
						item_q <= q_item;
						prev_q <= chm_pkg::NULL_LINK;
						if (q_item.func == chm_pkg::FUNC_CLEAR) begin
							state_q    <= S_CLR;
							clr_q      <= '0;
							clr_emit_q <= 1'b1;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					if (item_q.func == chm_pkg::FUNC_INSERT) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						out_value_q  <= '0;
						if (fh_q[SW]) begin
							out_status_q <= chm_pkg::ST_FULL;
							out_index_q  <= '0;
						end else begin
							out_status_q <= chm_pkg::ST_OK;
							out_index_q  <= fh_q[SW-1:0];
							fh_q <= fresh ? fh_q + LW'(1) : link_rd;
							if (fresh)
								hw_q <= fh_q + LW'(1);
						end
					end else if (head_rd[SW]) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						out_status_q <= chm_pkg::ST_NOTFOUND;
						out_value_q  <= '0;
						out_index_q  <= '0;
					end else begin
						state_q <= S_CMP;
						cur_q   <= head_rd;
					end
				end
				S_CMP: begin
					if (match) begin
						if (item_q.func == chm_pkg::FUNC_DELETE) begin
							state_q <= S_DEL;
						end else begin
							state_q      <= S_IDLE;
							out_valid_q  <= 1'b1;
							out_status_q <= chm_pkg::ST_OK;
							out_value_q  <= val_rd;
							out_index_q  <= cur_q[SW-1:0];
						end
					end else if (link_rd[SW]) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						out_status_q <= chm_pkg::ST_NOTFOUND;
						out_value_q  <= '0;
						out_index_q  <= '0;
					end else begin
						prev_q <= cur_q;
						cur_q  <= link_rd;
					end
				end
				S_DEL: begin
					state_q      <= S_IDLE;
					fh_q         <= cur_q;
					out_valid_q  <= 1'b1;
					out_status_q <= chm_pkg::ST_OK;
					out_value_q  <= '0;
					out_index_q  <= cur_q[SW-1:0];
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = out_value_q;
	assign rsp.entry_index = out_index_q;

endmodule

// ----- sv/chained_hash_map_core.sv -----
// Channel  Role    Contents
// req      sink    func, key, value
// rsp      source  status, found_value, entry_index
// cfg      write   bucket_count (cfg_we, cfg_wdata)
//
// The front stage reduces the key modulo the bucket count four bits per cycle,
// then pushes the request into the two-entry queue. The back stage reads the
// bucket head; insert finishes there, find and delete walk the chain, a delete
// hit adds an unlink step, and clear sweeps the bucket table. After reset all
// 1024 bucket heads are swept before the first request is served; the front
// may take up to three requests meanwhile.
// A stalled response holds the back stage, and the front once the queue fills.
module chained_hash_map_core (
	input  logic                      clk,
	input  logic                      arst_n,
	chm_req_if.sink                   req,
	chm_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [chm_pkg::CFG_W-1:0] cfg_wdata
);

	logic [chm_pkg::CFG_W-1:0] bucket_count_q;
	logic                      push;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_pop;
	chm_pkg::chm_item_t        push_item;
	chm_pkg::chm_item_t        pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bucket_count_q <= chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS);
		else if (cfg_we)
			bucket_count_q <= cfg_wdata;
	end

	chm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.bucket_count (bucket_count_q),
		.push         (push),
		.push_item    (push_item),
		.q_full       (q_full)
	);

	chm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_item  (pop_item)
	);

	chm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (pop_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("request popped from an empty queue");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != chm_pkg::ST_OK |->
			rsp.found_value == '0 && rsp.entry_index == '0)
		else $error("failed operation reports a non-zero value or slot");

endmodule
